// ----- design/assert_macros.svh -----
// Assertion helpers; clk and rst are the local clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/ldfg_pkg.sv -----
`default_nettype none
package ldfg_pkg;

  localparam int CHAIN_LENGTH = 4;
  localparam int BLANK_CODE   = 15;

  // Request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_NUMBER = 2'd1;
  localparam logic [1:0] REQ_BLANK  = 2'd2;

  // Driver register addresses: no-op, and digit register 0 (digits follow it)
  localparam logic [3:0] NOOP_ADDR   = 4'd0;
  localparam logic [3:0] DIGIT0_ADDR = 4'd1;

  localparam int          BIN_W    = 27;  // 99,999,999 < 2**27
  localparam logic [31:0] NUM_MAX  = 32'd99999999;
  localparam int          DIGITS   = 8;
  localparam int          BCD_W    = 4 * DIGITS;
  localparam logic [2:0]  LAST_POS = 3'(CHAIN_LENGTH - 1);
  localparam logic [7:0]  BLANK_BYTE = 8'(BLANK_CODE);

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  // Program steps
  localparam step_t ST_WAIT  = 3'd0;
  localparam step_t ST_CHECK = 3'd1;
  localparam step_t ST_INIT  = 3'd2;
  localparam step_t ST_SHIFT = 3'd3;
  localparam step_t ST_EMIT  = 3'd4;
  localparam step_t ST_DONE  = 3'd5;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_INPUT = 3'd2,
    COND_TYPE_BAD = 3'd3,
    COND_NOT_NUM  = 3'd4,
    COND_BCD_MORE = 3'd5,
    COND_EMIT_BSY = 3'd6
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  take;
    logic  bcd_init;
    logic  bcd_shift;
    logic  emit;
  } ctl_t;

  typedef struct packed {
    logic type_bad;
    logic not_num;
    logic bcd_more;
    logic emit_busy;
  } status_t;

  function automatic ctl_t ucode(input step_t step);
    ctl_t w;
    w = '{cond: COND_ALWAYS, target: ST_WAIT, take: 1'b0,
          bcd_init: 1'b0, bcd_shift: 1'b0, emit: 1'b0};
    unique case (step)
      ST_WAIT: begin
        w.cond = COND_NO_INPUT; w.target = ST_WAIT; w.take = 1'b1;
      end
      ST_CHECK: begin
        w.cond = COND_TYPE_BAD; w.target = ST_WAIT;
      end
      ST_INIT: begin
        w.cond = COND_NOT_NUM; w.target = ST_EMIT; w.bcd_init = 1'b1;
      end
      ST_SHIFT: begin
        w.cond = COND_BCD_MORE; w.target = ST_SHIFT; w.bcd_shift = 1'b1;
      end
      ST_EMIT: begin
        w.cond = COND_EMIT_BSY; w.target = ST_EMIT; w.emit = 1'b1;
      end
      ST_DONE: begin
        w.cond = COND_ALWAYS; w.target = ST_WAIT;
      end
      default: begin
        w.cond = COND_ALWAYS; w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- design/ldfg_seq.sv -----
`default_nettype none
`include "assert_macros.svh"
module ldfg_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire ldfg_pkg::status_t status,
  output ldfg_pkg::ctl_t        ctl
);
  import ldfg_pkg::*;

  step_t step, step_next;
  logic  jump;

  assign ctl = ucode(step);

  always_comb begin
    case (ctl.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_INPUT: jump = !in_valid;
      COND_TYPE_BAD: jump = status.type_bad;
      COND_NOT_NUM:  jump = status.not_num;
      COND_BCD_MORE: jump = status.bcd_more;
      COND_EMIT_BSY: jump = status.emit_busy;
      default:       jump = 1'b1;
    endcase
    step_next = jump ? ctl.target : step + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) step <= ST_WAIT;
    else     step <= step_next;
  end

  `ASSERT_CLK(a_take_starts, (ctl.take && in_valid) |=> (step == ST_CHECK), "take did not start")
  `ASSERT_CLK(a_step_range, (step <= ST_DONE), "step counter out of program")
  `ASSERT_CLK(a_done_returns, (step == ST_DONE) |=> (step == ST_WAIT), "done did not return")

endmodule
`default_nettype wire

// ----- design/ldfg_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"
module ldfg_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ldfg_pkg::ctl_t    ctl,
  input  wire logic              in_valid,
  input  wire logic [1:0]        req_type,
  input  wire logic [2:0]        unit,
  input  wire logic [3:0]        reg_address,
  input  wire logic [7:0]        reg_data,
  input  wire logic [31:0]       number,
  output ldfg_pkg::status_t      status,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [3:0]             cmd_address,
  output logic [7:0]             cmd_data,
  output logic                   frame_end,
  output logic                   last
);
  import ldfg_pkg::*;

  logic [1:0]       req;
  logic [2:0]       unit_r;
  logic [3:0]       addr_r;
  logic [7:0]       data_r;
  logic [BIN_W-1:0] bin;
  logic [BCD_W-1:0] bcd, bcd_adj;
  logic [4:0]       cnt;
  logic [2:0]       pos, digit;
  logic             load, word_end, word_last, hit;
  logic [3:0]       w_addr;
  logic [7:0]       w_data;

  // add-3 correction ahead of each doubling
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign load      = ctl.emit && (!out_valid || !out_stall);
  assign word_end  = (pos == LAST_POS);
  assign word_last = word_end && ((req == REQ_WRITE) || (digit == 3'(DIGITS - 1)));
  assign hit       = (pos == unit_r);

  always_comb begin
    if (req == REQ_WRITE) begin
      w_addr = addr_r;
      w_data = data_r;
    end else begin
      w_addr = {1'b0, digit} + DIGIT0_ADDR;
      w_data = (req == REQ_NUMBER) ? {4'd0, bcd[3:0]} : BLANK_BYTE;
    end
  end

  assign status.type_bad  = (req != REQ_WRITE) && (req != REQ_NUMBER) && (req != REQ_BLANK);
  assign status.not_num   = (req != REQ_NUMBER);
  assign status.bcd_more  = (cnt != 5'(BIN_W - 1));
  assign status.emit_busy = !(load && word_last);

  // request fields and conversion registers
  always_ff @(posedge clk) begin
    if (ctl.take && in_valid) begin
      req    <= req_type;
      unit_r <= unit;
      addr_r <= reg_address;
      data_r <= reg_data;
      bin    <= (number > NUM_MAX) ? NUM_MAX[BIN_W-1:0] : number[BIN_W-1:0];
    end
    if (ctl.bcd_init) begin
      bcd <= '0;
      cnt <= '0;
    end else if (ctl.bcd_shift) begin
      {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
      cnt        <= cnt + 5'd1;
    end else if (load && word_end) begin
      bcd <= {4'd0, bcd[BCD_W-1:4]};
    end
  end

  // word position within frame, digit counter
  always_ff @(posedge clk) begin
    if (rst || (ctl.take && in_valid)) begin
      pos   <= '0;
      digit <= '0;
    end else if (load) begin
      if (word_end) begin
        pos   <= '0;
        digit <= digit + 3'd1;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_address <= hit ? w_addr : NOOP_ADDR;
      cmd_data    <= hit ? w_data : 8'd0;
      frame_end   <= word_end;
      last        <= word_last;
    end
  end

  `ASSERT_CLK(a_pos_in_chain, (pos <= LAST_POS), "word position beyond chain")
  `ASSERT_CLK(a_last_ends_frame, (out_valid && last) |-> frame_end, "last word not at frame end")
  `ASSERT_CLK(a_digit_bcd, (ctl.emit && (req == REQ_NUMBER)) |-> (bcd[3:0] <= 4'd9), "bad digit")

endmodule
`default_nettype wire

// ----- design/led_driver_chain_frame_gen_core.sv -----
`default_nettype none
// Command word generator for a daisy chain of eight-digit LED driver chips.
// One request transaction (register write, decimal number, or blank) turns
// into chip-select frames of CHAIN_LENGTH words, chain position 0 first; the
// target chip gets the command and every other position a no-op (address 0,
// data 0). frame_end marks the word after which select is raised, last marks
// the final word of the request. Numbers above 99,999,999 show as 99,999,999;
// digits go out ones digit first, digit registers 0..7. A unit beyond the
// chain gives all-no-op frames; request type 3 is dropped with no words.
// One request at a time: no new request is taken until the last word of the
// current one is in the output register. A number first goes through the
// bit-serial binary-to-BCD pass. Output stalls hold the emit step. Control is
// a six-step microprogram; the word emit step runs at one word per cycle,
// while the output is not stalled, through a single output register.
module led_driver_chain_frame_gen_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // request transaction
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  unit,
  input  wire logic [3:0]  reg_address,
  input  wire logic [7:0]  reg_data,
  input  wire logic [31:0] number,
  // command word transaction
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       cmd_address,
  output logic [7:0]       cmd_data,
  output logic             frame_end,
  output logic             last
);
  import ldfg_pkg::*;

  ctl_t    ctl;
  status_t status;

  // ready only in the wait step of the program
  assign in_stall = !ctl.take;

  ldfg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctl      (ctl)
  );

  ldfg_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .in_valid    (in_valid),
    .req_type    (req_type),
    .unit        (unit),
    .reg_address (reg_address),
    .reg_data    (reg_data),
    .number      (number),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd_address (cmd_address),
    .cmd_data    (cmd_data),
    .frame_end   (frame_end),
    .last        (last)
  );

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ldfg_pkg::*;

  // Request type 3 has no package name; the block drops it without output.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_REQS   = 449;
  // The longest request is a number request; drain well past it.
  localparam int DRAIN_CYCLES  = 200;
  localparam int HOLD_CYCLES   = 3000;
  localparam int HOLD_AFTER    = 120;
  // Worst case: 8*CHAIN_LENGTH words each stalled the longest drawn wait, the
  // longest gap and the conversion pass per request, plus the long hold, taken
  // several times.
  localparam int CYCLE_LIMIT   = 2_500_000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  unit;
    logic [3:0]  addr;
    logic [7:0]  data;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } cmd_word_t;

  // ---------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type    = REQ_WRITE;
  logic [2:0]  unit        = 3'd0;
  logic [3:0]  reg_address = 4'd0;
  logic [7:0]  reg_data    = 8'd0;
  logic [31:0] number      = 32'd0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [3:0]  cmd_address;
  logic [7:0]  cmd_data;
  logic        frame_end;
  logic        last;

  always #5 clk = ~clk;

  led_driver_chain_frame_gen_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .unit        (unit),
    .reg_address (reg_address),
    .reg_data    (reg_data),
    .number      (number),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd_address (cmd_address),
    .cmd_data    (cmd_data),
    .frame_end   (frame_end),
    .last        (last)
  );

  // ---------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------
  request_t  requests_pending[$];   // filled up front, drained by the driver
  cmd_word_t cmd_words_due[$];      // predicted words, oldest first
  int        mismatches = 0;
  int        reqs_taken = 0;
  int        cycles     = 0;
  // Set at the rising edge from the handshake, read at the falling edge.
  bit        in_taken   = 1'b0;
  bit        out_taken  = 1'b0;
  bit        long_hold  = 1'b0;
  // A window of requests where neither side idles at all.
  wire       no_idle    = (reqs_taken >= 250) && (reqs_taken < 300);

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 4) == 0)
      return 0;
    return $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor: one chip-select frame is CHAIN_LENGTH words, position 0
  // first. Only the target position carries the command, the rest are
  // no-ops. A unit past the chain end matches nothing.
  // ---------------------------------------------------------------------
  task automatic add_frame(input logic [2:0] target, input logic [3:0] a,
                           input logic [7:0] d, input logic final_frame);
    cmd_word_t w;
    int        pos;
    for (pos = 0; pos < CHAIN_LENGTH; pos++) begin
      w.addr      = (pos == int'(target)) ? a : NOOP_ADDR;
      w.data      = (pos == int'(target)) ? d : 8'd0;
      w.frame_end = (pos == CHAIN_LENGTH - 1);
      w.last      = final_frame && (pos == CHAIN_LENGTH - 1);
      cmd_words_due.push_back(w);
    end
  endtask

  task automatic predict_cmd_words(input request_t r);
    logic [31:0] v;
    int          dg;
    case (r.kind)
      REQ_WRITE: begin
        add_frame(r.unit, r.addr, r.data, 1'b1);
      end
      REQ_NUMBER: begin
        // saturate to eight decimal digits, then ones digit first
        v = (r.value > NUM_MAX) ? NUM_MAX : r.value;
        for (dg = 0; dg < DIGITS; dg++) begin
          add_frame(r.unit, DIGIT0_ADDR + 4'(dg), 8'(v % 32'd10), dg == DIGITS - 1);
          v = v / 32'd10;
        end
      end
      REQ_BLANK: begin
        for (dg = 0; dg < DIGITS; dg++)
          add_frame(r.unit, DIGIT0_ADDR + 4'(dg), BLANK_BYTE, dg == DIGITS - 1);
      end
      default: begin
        // unused type: no words
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. An accepted request
  // is predicted from the payload the driver holds; an accepted word is
  // checked against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      in_taken  = !rst && in_valid && !in_stall;
      out_taken = !rst && out_valid && !out_stall;
      if (in_taken) begin
        predict_cmd_words('{kind: req_type, unit: unit, addr: reg_address,
                            data: reg_data, value: number});
        reqs_taken++;
      end
      if (out_taken) begin
        if (cmd_words_due.size() == 0) begin
          mismatches++;
          $display("%0t: word with none due: addr %0h data %0h end %0b last %0b",
                   $time, cmd_address, cmd_data, frame_end, last);
        end else begin
          cmd_word_t exp_w;
          exp_w = cmd_words_due.pop_front();
          if (cmd_address !== exp_w.addr) begin
            mismatches++;
            $display("%0t: cmd_address expected %0h actual %0h",
                     $time, exp_w.addr, cmd_address);
          end
          if (cmd_data !== exp_w.data) begin
            mismatches++;
            $display("%0t: cmd_data expected %0h actual %0h",
                     $time, exp_w.data, cmd_data);
          end
          if (frame_end !== exp_w.frame_end) begin
            mismatches++;
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, exp_w.frame_end, frame_end);
          end
          if (last !== exp_w.last) begin
            mismatches++;
            $display("%0t: last expected %0b actual %0b",
                     $time, exp_w.last, last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request driver: changes inputs at the falling edge. After each
  // transaction it waits a drawn number of cycles before the next one;
  // with zero wait valid simply stays high with the next payload.
  // ---------------------------------------------------------------------
  int       gap_left = 0;
  request_t next_req;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken)
        gap_left = draw_wait();
      // a stalled payload is held until it goes through
      if (!in_valid || in_taken) begin
        if (gap_left == 0 && requests_pending.size() > 0) begin
          next_req    = requests_pending.pop_front();
          in_valid    <= 1'b1;
          req_type    <= next_req.kind;
          unit        <= next_req.unit;
          reg_address <= next_req.addr;
          reg_data    <= next_req.data;
          number      <= next_req.value;
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0)
            gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Word receiver: stalls a drawn number of cycles after each accepted
  // word, and for the whole long hold-off.
  // ---------------------------------------------------------------------
  int stall_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_taken)
        stall_left = draw_wait();
      out_stall <= long_hold || (stall_left > 0);
      if (stall_left > 0)
        stall_left--;
    end
  end

  // Long hold-off: the receiver stops taking words while the driver keeps
  // offering requests, so the block backs up and stalls its input.
  initial begin
    wait (reqs_taken >= HOLD_AFTER);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  task automatic queue_req(input logic [1:0] k, input logic [2:0] u,
                           input logic [3:0] a, input logic [7:0] d,
                           input logic [31:0] v);
    requests_pending.push_back('{kind: k, unit: u, addr: a, data: d, value: v});
  endtask

  initial begin
    request_t r;
    int       counted;
    int       pick;

    // directed: field extremes, every request type, the special cases
    queue_req(REQ_WRITE, 3'd0, 4'd0, 8'd0, 32'd0);
    queue_req(REQ_WRITE, LAST_POS, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    queue_req(REQ_WRITE, 3'd1, 4'hA, 8'h5A, 32'd0);
    queue_req(REQ_WRITE, 3'd2, 4'hC, 8'h01, 32'd0);
    queue_req(REQ_WRITE, 3'd7, 4'h9, 8'hA5, 32'd0);          // unit past chain
    queue_req(REQ_WRITE, 3'd4, 4'h3, 8'h80, 32'd0);          // first unit past chain
    queue_req(REQ_NUMBER, 3'd0, 4'd0, 8'd0, 32'd0);
    queue_req(REQ_NUMBER, 3'd1, 4'd0, 8'd0, 32'd12345678);
    queue_req(REQ_NUMBER, 3'd2, 4'd0, 8'd0, NUM_MAX);
    queue_req(REQ_NUMBER, LAST_POS, 4'd0, 8'd0, NUM_MAX + 32'd1); // saturates
    queue_req(REQ_NUMBER, 3'd0, 4'hF, 8'hFF, 32'hFFFF_FFFF);      // saturates
    queue_req(REQ_NUMBER, 3'd1, 4'd0, 8'd0, 32'd9);
    queue_req(REQ_NUMBER, 3'd2, 4'd0, 8'd0, 32'd10);
    queue_req(REQ_NUMBER, 3'd3, 4'd0, 8'd0, 32'd90909090);
    queue_req(REQ_NUMBER, 3'd5, 4'd0, 8'd0, 32'd87654321);   // unit past chain
    queue_req(REQ_BLANK, 3'd0, 4'd0, 8'd0, 32'd0);
    queue_req(REQ_BLANK, 3'd7, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    queue_req(REQ_UNUSED, 3'd1, 4'h5, 8'h33, 32'd42);        // dropped
    queue_req(REQ_UNUSED, 3'd0, 4'd0, 8'd0, 32'd0);          // dropped
    queue_req(REQ_WRITE, 3'd3, 4'h1, 8'h7E, 32'd0);          // right after drops
    queue_req(REQ_BLANK, 3'd3, 4'd0, 8'd0, 32'd0);

    // random mix, dropped types included
    counted = 0;
    while (counted < RANDOM_REQS) begin
      pick    = $urandom_range(0, 99);
      r.kind  = (pick < 40) ? REQ_WRITE : (pick < 75) ? REQ_NUMBER :
                (pick < 90) ? REQ_BLANK : REQ_UNUSED;
      r.unit  = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7))
                                             : 3'($urandom_range(0, 3));
      r.addr  = 4'($urandom);
      r.data  = 8'($urandom);
      case ($urandom_range(0, 3))
        0:       r.value = $urandom;
        1:       r.value = $urandom_range(0, 99999999);
        2:       r.value = $urandom_range(0, 999);
        default: r.value = $urandom_range(99999990, 100000010);
      endcase
      counted++;
      requests_pending.push_back(r);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all requests through, all words in, then let any stray word show up
    do @(posedge clk); while (requests_pending.size() != 0 || in_valid);
    while (cmd_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
